// ----- sv/bracket_tape_machine_core_defines.svh -----
// Assertion macros for the bracket tape machine core.
// Define NO_ASSERTIONS to compile them away.
`ifndef BRACKET_TAPE_MACHINE_CORE_DEFINES_SVH
`define BRACKET_TAPE_MACHINE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/btm_pkg.sv -----
// Shared types and constants for the bracket tape machine core.
// No dependencies.
`timescale 1ns / 1ps
package btm_pkg;
    localparam int ProgDepth = 4096;
    localparam int TapeDepth = 32768;
    localparam int NestDepth = 256;
    localparam int PAW = $clog2(ProgDepth);
    localparam int TAW = $clog2(TapeDepth);
    localparam int NAW = $clog2(NestDepth);

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CLOSE    = 3'd1;
    localparam logic [2:0] ERR_OPEN     = 3'd2;
    localparam logic [2:0] ERR_RANGE    = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] program_byte;
        logic [7:0] in_byte;
        logic       in_valid;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       input_used;
        logic       waiting_input;
        logic       halted;
        logic [2:0] error_code;
    } t_out;

    // queue entry between front and back
    typedef struct packed {
        logic       restart;
        logic       step;   // a step command; it may end without executing an instruction
        logic [7:0] in_byte;
        logic       in_valid;
    } t_job;
endpackage

// ----- sv/btm_front.sv -----
// Front end: accepts commands, loads the program and bracket tables.
// Depends on btm_pkg. Owns program store and partner table.
`timescale 1ns / 1ps
`include "bracket_tape_machine_core_defines.svh"
module btm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  btm_pkg::t_in     i_item,
    input  logic             i_exec_fault,
    input  logic [btm_pkg::PAW-1:0] i_fetch_addr,
    output logic [7:0]       o_fetch_op,
    output logic [btm_pkg::PAW-1:0] o_fetch_partner,
    output logic [btm_pkg::PAW:0]   o_prog_len,
    output logic             o_nest_empty,
    output logic             o_load_fault,
    output logic [2:0]       o_load_code,
    output logic             o_clear
);
    import btm_pkg::*;

    logic [7:0]     r_prog [ProgDepth];
    logic [PAW-1:0] r_part [ProgDepth];
    logic [PAW-1:0] r_stk  [NestDepth];
    logic [NAW:0]   r_sp, n_sp;
    logic [PAW:0]   r_len, n_len;
    logic           r_fault, n_fault;
    logic [2:0]     r_code, n_code;
    logic [PAW-1:0] r_open_pos;
    logic [PAW-1:0] r_close_pos;
    logic           r_pw;
    logic           r_pw2;
    logic [7:0]     r_op;
    logic [PAW-1:0] r_pt;

    logic is_load, wr_prog, push, pop;
    logic [PAW-1:0] pos;
    // a fault on either side blocks loading
    assign is_load = i_go && i_item.cmd == CMD_LOAD && !r_fault && !i_exec_fault;
    assign pos = r_len[PAW-1:0];

    always_comb begin
        n_sp = r_sp; n_len = r_len; n_fault = r_fault; n_code = r_code;
        wr_prog = 1'b0; push = 1'b0; pop = 1'b0;
        if (i_go && i_item.cmd == CMD_RESTART) begin
            n_sp = '0; n_len = '0; n_fault = 1'b0; n_code = ERR_NONE;
        end else if (is_load) begin
            priority if (r_len == (PAW+1)'(ProgDepth)) begin
                n_fault = 1'b1; n_code = ERR_OVERFLOW;
            end else if (i_item.program_byte == CH_OPEN &&
                         r_sp == (NAW+1)'(NestDepth)) begin
                n_fault = 1'b1; n_code = ERR_OVERFLOW;
            end else if (i_item.program_byte == CH_CLOSE && r_sp == '0) begin
                n_fault = 1'b1; n_code = ERR_CLOSE;
            end else begin
                wr_prog = 1'b1;
                n_len = r_len + 1'b1;
                push = i_item.program_byte == CH_OPEN;
                pop  = i_item.program_byte == CH_CLOSE;
                if (push) n_sp = r_sp + 1'b1;
                if (pop)  n_sp = r_sp - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_len <= '0; r_fault <= 1'b0; r_code <= ERR_NONE; r_pw <= 1'b0;
            r_pw2 <= 1'b0;
        end else begin
            r_sp <= n_sp; r_len <= n_len; r_fault <= n_fault; r_code <= n_code;
            r_pw <= pop;
            r_pw2 <= r_pw;
        end
    end

    // stack and program memory writes; a pop reads the stack into a register
    // and holds the close position for the partner writes
    always_ff @(posedge i_clk) begin
        if (wr_prog) r_prog[pos] <= i_item.program_byte;
        if (push) r_stk[r_sp[NAW-1:0]] <= pos;
        if (pop) begin
            r_open_pos  <= r_stk[n_sp[NAW-1:0]];
            r_close_pos <= pos;
        end
    end

    // partner table: close entry the cycle after the pop, open entry the next
    always_ff @(posedge i_clk) begin
        if (r_pw) r_part[r_close_pos] <= r_open_pos;
        else if (r_pw2) r_part[r_open_pos] <= r_close_pos;
        r_op <= r_prog[i_fetch_addr];
        r_pt <= r_part[i_fetch_addr];
    end

    assign o_fetch_op = r_op;
    assign o_fetch_partner = r_pt;
    assign o_prog_len = r_len;
    assign o_nest_empty = r_sp == '0;
    assign o_load_fault = r_fault;
    assign o_load_code = r_code;
    assign o_clear = i_go && i_item.cmd == CMD_RESTART;

    `BTM_ASSERT_IMP(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= (NAW+1)'(NestDepth))
    `BTM_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= (PAW+1)'(ProgDepth))
    `BTM_ASSERT_NXT(a_fault_sticky, i_clk, i_rst_n, r_fault && !o_clear, r_fault)
endmodule

// ----- sv/btm_back.sv -----
// Back end: executes at most one instruction per job against the tape memory and sweeps the tape on reset and restart.
// Depends on btm_pkg; reads program and partner data from btm_front.
`timescale 1ns / 1ps
`include "bracket_tape_machine_core_defines.svh"
module btm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  btm_pkg::t_job    i_job,
    output logic             o_job_take,
    output logic [btm_pkg::PAW-1:0] o_fetch_addr,
    input  logic [7:0]       i_fetch_op,
    input  logic [btm_pkg::PAW-1:0] i_fetch_partner,
    input  logic [btm_pkg::PAW:0]   i_prog_len,
    input  logic             i_nest_empty,
    input  logic             i_load_fault,
    input  logic [2:0]       i_load_code,
    output logic             o_idle,
    output logic             o_res_valid,
    output btm_pkg::t_out    o_res,
    output logic             o_clearing,
    output logic             o_fault
);
    import btm_pkg::*;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_EX   = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state         r_st, n_st;
    logic [7:0]     r_tape [TapeDepth];
    logic [TAW-1:0] r_cp, n_cp;
    logic [PAW:0]   r_pc, n_pc;
    logic           r_fault, n_fault;
    logic [2:0]     r_code, n_code;
    logic [TAW:0]   r_clr, n_clr;
    logic           r_pend, n_pend;   // sweep belongs to a restart that owes a result
    logic [7:0]     r_cell;
    t_job           r_job;
    logic           r_rv, n_rv;
    t_out           r_res, n_res;
    logic           we;
    logic [7:0]     wd;

    assign o_fetch_addr = r_pc[PAW-1:0];
    assign o_idle = r_st == S_IDLE;
    assign o_job_take = (r_st == S_IDLE || r_st == S_CLR) && i_job_valid;
    assign o_clearing = r_st == S_CLR;
    assign o_fault = r_fault;

    logic fault_any;
    logic [2:0] code_any;
    assign fault_any = i_load_fault || r_fault;
    assign code_any = i_load_fault ? i_load_code : r_code;

    always_comb begin
        n_st = r_st; n_cp = r_cp; n_pc = r_pc; n_fault = r_fault; n_code = r_code;
        n_clr = r_clr; n_pend = r_pend; n_rv = 1'b0; n_res = r_res; we = 1'b0; wd = r_cell;
        unique case (r_st)
            S_CLR: begin
                we = 1'b1; wd = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == (TAW+1)'(TapeDepth - 1)) begin
                    n_st = r_pend ? S_WB : S_IDLE;
                    n_pend = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.restart) begin
                        n_st = S_CLR; n_clr = '0; n_cp = '0; n_pc = '0;
                        n_fault = 1'b0; n_code = ERR_NONE; n_pend = 1'b1;
                    end else if (i_job.step && !fault_any && !i_nest_empty) begin
                        n_fault = 1'b1; n_code = ERR_OPEN;
                        n_st = S_WB;
                    end else if (i_job.step && !fault_any && r_pc < i_prog_len) begin
                        n_st = S_RD;
                    end else begin
                        n_st = S_WB;
                    end
                end
            end
            S_RD: n_st = S_EX;
            S_EX: begin
                n_st = S_WB;
                n_pc = r_pc + 1'b1;
                unique case (i_fetch_op)
                    CH_LEFT: begin
                        if (r_cp == '0) begin
                            n_fault = 1'b1; n_code = ERR_RANGE; n_pc = r_pc;
                        end else n_cp = r_cp - 1'b1;
                    end
                    CH_RIGHT: begin
                        if (r_cp == TAW'(TapeDepth - 1)) begin
                            n_fault = 1'b1; n_code = ERR_RANGE; n_pc = r_pc;
                        end else n_cp = r_cp + 1'b1;
                    end
                    CH_INC: begin we = 1'b1; wd = r_cell + 8'd1; end
                    CH_DEC: begin we = 1'b1; wd = r_cell - 8'd1; end
                    CH_IN: begin
                        if (r_job.in_valid) begin
                            we = 1'b1; wd = r_job.in_byte;
                        end else n_pc = r_pc;
                    end
                    CH_OPEN: if (r_cell == '0) n_pc = {1'b0, i_fetch_partner} + 1'b1;
                    CH_CLOSE: if (r_cell != '0) n_pc = {1'b0, i_fetch_partner} + 1'b1;
                    default: ;
                endcase
                n_res = '0;
                n_res.out_byte = (i_fetch_op == CH_OUT) ? r_cell : 8'd0;
                n_res.out_valid = i_fetch_op == CH_OUT;
                n_res.input_used = i_fetch_op == CH_IN && r_job.in_valid;
                n_res.waiting_input = i_fetch_op == CH_IN && !r_job.in_valid;
            end
            S_WB: begin
                n_st = S_IDLE;
                n_rv = 1'b1;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_cp <= '0; r_pc <= '0; r_fault <= 1'b0;
            r_code <= ERR_NONE; r_clr <= '0; r_rv <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_st <= n_st; r_cp <= n_cp; r_pc <= n_pc; r_fault <= n_fault;
            r_code <= n_code; r_clr <= n_clr; r_rv <= n_rv; r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE) begin
            r_job <= i_job;
            r_res <= '0;
        end else r_res <= n_res;
        if (we) r_tape[r_st == S_CLR ? r_clr[TAW-1:0] : r_cp] <= wd;
        r_cell <= r_tape[r_cp];
    end

    assign o_res_valid = r_rv;
    always_comb begin
        o_res = r_res;
        o_res.halted = fault_any || r_pc >= i_prog_len;
        o_res.error_code = fault_any ? code_any : ERR_NONE;
    end

    `BTM_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_st))
    `BTM_ASSERT_NXT(a_wb_emit, i_clk, i_rst_n, r_st == S_WB, r_rv && r_st == S_IDLE)
    `BTM_ASSERT_IMP(a_res_excl, i_clk, i_rst_n, r_rv, !(r_res.input_used && r_res.waiting_input))
endmodule

// ----- sv/btm_queue.sv -----
// Two-entry job queue between front end and back end.
// Depends on btm_pkg.
`timescale 1ns / 1ps
module btm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  btm_pkg::t_job i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output btm_pkg::t_job o_data,
    output logic          o_full
);
    import btm_pkg::*;
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
    assign o_valid = r_cnt != '0;
    assign o_data = r_mem[r_rp];
    assign o_full = r_cnt == 2'd2;
endmodule

// ----- sv/bracket_tape_machine_core.sv -----
// Bracket tape machine core: program loading up front, tape execution in back.
// Depends on btm_pkg, btm_front, btm_queue, btm_back and the defines header.
//
// Usage: drive i_item and pulse start while busy is low; every transfer gives
// exactly one result, shown for one cycle with o_res_valid. A load, the unused
// command or a step that executes nothing is taken by the back end from the
// queue, written back (S_WB) and its result is shown; an executing step adds
// the program and tape read (S_RD) and the execute state (S_EX) before the
// write-back. busy stays high through the result cycle and admits one item at
// a time, so the next transfer can come only after the result has been shown.
// After reset all 32768 tape cells are swept to zero, during which busy stays
// high. A restart also sweeps the tape before its result is shown. The receiver
// cannot stall: results must be taken as shown.
`timescale 1ns / 1ps
module bracket_tape_machine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  btm_pkg::t_in  i_item,
    output logic          o_res_valid,
    output btm_pkg::t_out o_res
);
    import btm_pkg::*;

    logic go, r_busy;
    logic [7:0] fop; logic [PAW-1:0] fpart, faddr; logic [PAW:0] plen;
    logic nest_empty, lfault, clr, idle, take, qv, qfull, clearing, xfault;
    logic [2:0] lcode;
    t_job job, qd;

    assign go = start && !busy;
    // busy covers the clear sweep and one outstanding item at a time
    assign busy = r_busy || clearing || !idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else if (go) r_busy <= 1'b1;
        else if (o_res_valid) r_busy <= 1'b0;
    end

    always_comb begin
        job.restart = i_item.cmd == CMD_RESTART;
        job.step = i_item.cmd == CMD_STEP;
        job.in_byte = i_item.in_byte;
        job.in_valid = i_item.in_valid;
    end

    // execution faults also block loads in the front end
    btm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_item(i_item),
        .i_exec_fault(xfault),
        .i_fetch_addr(faddr), .o_fetch_op(fop), .o_fetch_partner(fpart),
        .o_prog_len(plen), .o_nest_empty(nest_empty), .o_load_fault(lfault),
        .o_load_code(lcode), .o_clear(clr)
    );

    btm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(go), .i_data(job),
        .i_pop(take && !clearing), .o_valid(qv), .o_data(qd), .o_full(qfull)
    );

    btm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(qv && !clearing), .i_job(qd),
        .o_job_take(take), .o_fetch_addr(faddr), .i_fetch_op(fop),
        .i_fetch_partner(fpart), .i_prog_len(plen), .i_nest_empty(nest_empty),
        .i_load_fault(lfault && !clr && !qfull), .i_load_code(lcode), .o_idle(idle),
        .o_res_valid(o_res_valid), .o_res(o_res), .o_clearing(clearing),
        .o_fault(xfault)
    );
endmodule
